// ----- rtl/core/ctrmv_pkg.sv -----
package ctrmv_pkg;

    // Field widths
    localparam int EtaW    = 12;
    localparam int PhiW    = 12;
    localparam int EnergyW = 16;
    localparam int EdgeW   = 11;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 12;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_CONE_PHI_HALF      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_CONE_ETA_HALF      = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_EM_BARREL_EDGE     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_HAD_BARREL_EDGE    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ENDCAP_OUTER_EDGE  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_FORWARD_INNER_EDGE = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_FORWARD_OUTER_EDGE = 3'd6;

    // Register reset values (eta in 1/256, phi in 4096 per turn)
    localparam logic [PhiW-1:0]  RST_CONE_PHI_HALF      = 12'd456;
    localparam logic [EdgeW-1:0] RST_CONE_ETA_HALF      = 11'd38;
    localparam logic [EdgeW-1:0] RST_EM_BARREL_EDGE     = 11'd379;
    localparam logic [EdgeW-1:0] RST_HAD_BARREL_EDGE    = 11'd334;
    localparam logic [EdgeW-1:0] RST_ENDCAP_OUTER_EDGE  = 11'd768;
    localparam logic [EdgeW-1:0] RST_FORWARD_INNER_EDGE = 11'd742;
    localparam logic [EdgeW-1:0] RST_FORWARD_OUTER_EDGE = 11'd1331;

    typedef struct packed {
        logic                      first_tower;
        logic                      last_tower;
        logic signed [EtaW-1:0]    tower_eta;
        logic [PhiW-1:0]           tower_phi;
        logic [EnergyW-1:0]        tower_em_energy;
        logic [EnergyW-1:0]        tower_had_energy;
        logic [EnergyW-1:0]        tower_total_energy;
        logic signed [EtaW-1:0]    lead_eta;
        logic [PhiW-1:0]           lead_phi;
        logic signed [EtaW-1:0]    second_eta;
        logic [PhiW-1:0]           second_phi;
    } tower_in_t;

    typedef struct packed {
        logic [EnergyW-1:0] em_barrel_max;
        logic [EnergyW-1:0] em_endcap_max;
        logic [EnergyW-1:0] had_barrel_max;
        logic [EnergyW-1:0] had_endcap_max;
        logic [EnergyW-1:0] fwd_plus_max;
        logic [EnergyW-1:0] fwd_minus_max;
    } peaks_out_t;

endpackage

// ----- rtl/core/calo_tower_region_max_veto_unit.sv -----
// Channel   Ports                                   Direction  Beat
// s_        s_valid s_ready s_data                  in         one tower
// m_        m_valid m_ready m_data                  out        six region maxima
// cfg_      cfg_valid cfg_ready cfg_index cfg_data  in         one register write
//
// One tower per cycle unless a last tower stalls; a beat is held in the input register
// and its result, when last_tower is set, is registered in the output register.
// Region tests, cone veto and max update are one combinational pass between them.
// Reset (aresetn low, synchronous) empties both registers, zeroes the maxima and
// loads the default region edges and cone sizes. A last tower stalls only while the
// output register still holds an untaken result; other towers never stall.
module calo_tower_region_max_veto_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ctrmv_pkg::tower_in_t              s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ctrmv_pkg::peaks_out_t             m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ctrmv_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [ctrmv_pkg::CfgDatW-1:0]     cfg_data
);
    import ctrmv_pkg::*;

    // Configuration registers
    logic [PhiW-1:0]  cone_phi_half_reg;
    logic [EdgeW-1:0] cone_eta_half_reg;
    logic [EdgeW-1:0] em_barrel_edge_reg;
    logic [EdgeW-1:0] had_barrel_edge_reg;
    logic [EdgeW-1:0] endcap_outer_edge_reg;
    logic [EdgeW-1:0] forward_inner_edge_reg;
    logic [EdgeW-1:0] forward_outer_edge_reg;

    // Datapath registers
    logic       in_vld_reg;
    tower_in_t  in_reg;
    logic       out_vld_reg;
    peaks_out_t out_reg;
    peaks_out_t peak_reg;
    peaks_out_t peak_next;

    logic adv;

    // Cone membership: wrapped phi difference and eta difference, both strict
    function automatic logic in_cone(
        input logic signed [EtaW-1:0] teta,
        input logic [PhiW-1:0]        tphi,
        input logic signed [EtaW-1:0] eeta,
        input logic [PhiW-1:0]        ephi,
        input logic [PhiW-1:0]        phi_half,
        input logic [EdgeW-1:0]       eta_half
    );
        logic signed [PhiW-1:0] dphi;
        logic [PhiW:0]          dphi_mag;
        logic signed [EtaW:0]   deta;
        logic [EtaW:0]          deta_mag;
        dphi     = signed'(tphi - ephi);
        dphi_mag = dphi[PhiW-1] ? (13'd0 - {dphi[PhiW-1], dphi}) : {1'b0, dphi};
        deta     = {teta[EtaW-1], teta} - {eeta[EtaW-1], eeta};
        deta_mag = deta[EtaW] ? (13'd0 - deta) : deta;
        return (dphi_mag < {1'b0, phi_half}) && (deta_mag < {2'b00, eta_half});
    endfunction

    // Update one peak when the energy is strictly greater
    function automatic logic [EnergyW-1:0] raise(
        input logic [EnergyW-1:0] cur,
        input logic [EnergyW-1:0] e,
        input logic               hit
    );
        return (hit && e > cur) ? e : cur;
    endfunction

    // Handshakes
    assign adv       = in_vld_reg && (!in_reg.last_tower || !out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || adv;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;

    // Region tests and veto on the registered tower
    logic signed [EtaW:0] eta_x;
    logic [EtaW-1:0]      a;
    logic [EtaW-1:0]      em_edge_x, had_edge_x, out_edge_x;
    logic signed [EtaW:0] fi_x, fo_x;
    logic                 em_b, em_e, had_b, had_e, fwd_p, fwd_m;
    logic                 vetoed;
    peaks_out_t           base;

    always_comb begin
        eta_x      = {in_reg.tower_eta[EtaW-1], in_reg.tower_eta};
        a          = eta_x[EtaW] ? EtaW'(13'd0 - eta_x) : eta_x[EtaW-1:0];
        em_edge_x  = {1'b0, em_barrel_edge_reg};
        had_edge_x = {1'b0, had_barrel_edge_reg};
        out_edge_x = {1'b0, endcap_outer_edge_reg};
        fi_x       = signed'({2'b00, forward_inner_edge_reg});
        fo_x       = signed'({2'b00, forward_outer_edge_reg});

        em_b  = a < em_edge_x;
        em_e  = (a > em_edge_x) && (a < out_edge_x);
        had_b = a < had_edge_x;
        had_e = (a > had_edge_x) && (a < out_edge_x);
        fwd_p = (eta_x > fi_x) && (eta_x < fo_x);
        fwd_m = (eta_x < -fi_x) && (eta_x > -fo_x);

        vetoed = (em_b || em_e) &&
                 (in_cone(in_reg.tower_eta, in_reg.tower_phi, in_reg.lead_eta,
                          in_reg.lead_phi, cone_phi_half_reg, cone_eta_half_reg) ||
                  in_cone(in_reg.tower_eta, in_reg.tower_phi, in_reg.second_eta,
                          in_reg.second_phi, cone_phi_half_reg, cone_eta_half_reg));

        base = in_reg.first_tower ? '0 : peak_reg;

        peak_next.em_barrel_max  = raise(base.em_barrel_max, in_reg.tower_em_energy,
                                         em_b && !vetoed);
        peak_next.em_endcap_max  = raise(base.em_endcap_max, in_reg.tower_em_energy,
                                         em_e && !vetoed);
        peak_next.had_barrel_max = raise(base.had_barrel_max, in_reg.tower_had_energy,
                                         had_b && !vetoed);
        peak_next.had_endcap_max = raise(base.had_endcap_max, in_reg.tower_had_energy,
                                         had_e && !vetoed);
        peak_next.fwd_plus_max   = raise(base.fwd_plus_max, in_reg.tower_total_energy,
                                         fwd_p && !vetoed);
        peak_next.fwd_minus_max  = raise(base.fwd_minus_max, in_reg.tower_total_energy,
                                         fwd_m && !vetoed);
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cone_phi_half_reg      <= RST_CONE_PHI_HALF;
            cone_eta_half_reg      <= RST_CONE_ETA_HALF;
            em_barrel_edge_reg     <= RST_EM_BARREL_EDGE;
            had_barrel_edge_reg    <= RST_HAD_BARREL_EDGE;
            endcap_outer_edge_reg  <= RST_ENDCAP_OUTER_EDGE;
            forward_inner_edge_reg <= RST_FORWARD_INNER_EDGE;
            forward_outer_edge_reg <= RST_FORWARD_OUTER_EDGE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CONE_PHI_HALF:      cone_phi_half_reg      <= cfg_data;
                REG_CONE_ETA_HALF:      cone_eta_half_reg      <= cfg_data[EdgeW-1:0];
                REG_EM_BARREL_EDGE:     em_barrel_edge_reg     <= cfg_data[EdgeW-1:0];
                REG_HAD_BARREL_EDGE:    had_barrel_edge_reg    <= cfg_data[EdgeW-1:0];
                REG_ENDCAP_OUTER_EDGE:  endcap_outer_edge_reg  <= cfg_data[EdgeW-1:0];
                REG_FORWARD_INNER_EDGE: forward_inner_edge_reg <= cfg_data[EdgeW-1:0];
                REG_FORWARD_OUTER_EDGE: forward_outer_edge_reg <= cfg_data[EdgeW-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    // Running maxima
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg <= '0;
        end else if (adv) begin
            peak_reg <= peak_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv && in_reg.last_tower) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_reg.last_tower) begin
            out_reg <= peak_next;
        end
    end

    // Checks
    a_rise_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(adv && in_reg.last_tower))
        else $error("result appeared without a last tower");

    a_mid_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !in_reg.last_tower |-> s_ready)
        else $error("non-last tower stalled the input");

    a_first_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_reg.first_tower |=>
            (peak_reg.em_barrel_max == '0 ||
             peak_reg.em_barrel_max == $past(in_reg.tower_em_energy)))
        else $error("first tower did not restart the EM barrel maximum");

    a_out_matches_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_reg.last_tower |=> out_reg == peak_reg)
        else $error("emitted maxima differ from running maxima");

endmodule

// ----- dv/calo_tower_region_max_veto_unit_tb.sv -----
`timescale 1ns / 100ps

import ctrmv_pkg::*;

// Predicts the six region maxima per event and matches them against the block output
class veto_peak_tracker;
    int phi_half;
    int eta_half;
    int em_edge;
    int had_edge;
    int endcap_edge;
    int fwd_inner;
    int fwd_outer;

    peaks_out_t running;
    peaks_out_t expected_peaks[$];
    string      field_names[6];

    int towers_seen;
    int results_checked;
    int mismatches;

    function new();
        phi_half    = RST_CONE_PHI_HALF;
        eta_half    = RST_CONE_ETA_HALF;
        em_edge     = RST_EM_BARREL_EDGE;
        had_edge    = RST_HAD_BARREL_EDGE;
        endcap_edge = RST_ENDCAP_OUTER_EDGE;
        fwd_inner   = RST_FORWARD_INNER_EDGE;
        fwd_outer   = RST_FORWARD_OUTER_EDGE;
        running     = '0;
        field_names = '{"em_barrel_max", "em_endcap_max", "had_barrel_max",
                        "had_endcap_max", "fwd_plus_max", "fwd_minus_max"};
    endfunction

    // Register write; edge registers keep 11 bits
    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
        case (idx)
            REG_CONE_PHI_HALF:      phi_half    = val;
            REG_CONE_ETA_HALF:      eta_half    = val[EdgeW-1:0];
            REG_EM_BARREL_EDGE:     em_edge     = val[EdgeW-1:0];
            REG_HAD_BARREL_EDGE:    had_edge    = val[EdgeW-1:0];
            REG_ENDCAP_OUTER_EDGE:  endcap_edge = val[EdgeW-1:0];
            REG_FORWARD_INNER_EDGE: fwd_inner   = val[EdgeW-1:0];
            REG_FORWARD_OUTER_EDGE: fwd_outer   = val[EdgeW-1:0];
            default: ;
        endcase
    endfunction

    // Phi difference wraps to [-2048, 2047]; both bounds strict
    function bit in_electron_cone(int teta, int tphi, int eeta, int ephi);
        int dphi;
        int deta;
        dphi = (tphi - ephi) & 'hFFF;
        if (dphi >= 2048) dphi -= 4096;
        if (dphi < 0) dphi = -dphi;
        deta = teta - eeta;
        if (deta < 0) deta = -deta;
        return (dphi < phi_half) && (deta < eta_half);
    endfunction

    function logic [EnergyW-1:0] higher_of(logic [EnergyW-1:0] pk, logic [EnergyW-1:0] e);
        return (e > pk) ? e : pk;
    endfunction

    // Accepted tower: update running peaks, queue a result on last_tower
    function void note_tower(tower_in_t t);
        int eta;
        int mag;
        bit em_b;
        bit em_e;
        bit vetoed;
        eta = $signed(t.tower_eta);
        mag = (eta < 0) ? -eta : eta;
        towers_seen++;
        if (t.first_tower) running = '0;
        em_b = mag < em_edge;
        em_e = (mag > em_edge) && (mag < endcap_edge);
        vetoed = (em_b || em_e) &&
                 (in_electron_cone(eta, t.tower_phi, $signed(t.lead_eta), t.lead_phi) ||
                  in_electron_cone(eta, t.tower_phi, $signed(t.second_eta), t.second_phi));
        if (!vetoed) begin
            if (em_b)
                running.em_barrel_max = higher_of(running.em_barrel_max, t.tower_em_energy);
            if (em_e)
                running.em_endcap_max = higher_of(running.em_endcap_max, t.tower_em_energy);
            if (mag < had_edge)
                running.had_barrel_max = higher_of(running.had_barrel_max, t.tower_had_energy);
            if (mag > had_edge && mag < endcap_edge)
                running.had_endcap_max = higher_of(running.had_endcap_max, t.tower_had_energy);
            if (eta > fwd_inner && eta < fwd_outer)
                running.fwd_plus_max = higher_of(running.fwd_plus_max, t.tower_total_energy);
            if (eta < -fwd_inner && eta > -fwd_outer)
                running.fwd_minus_max = higher_of(running.fwd_minus_max, t.tower_total_energy);
        end
        if (t.last_tower) expected_peaks = {expected_peaks, running};
    endfunction

    function void count_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    // Result beat: compare each field with the oldest expectation
    function void check_peaks(peaks_out_t got);
        peaks_out_t         want;
        logic [EnergyW-1:0] w;
        logic [EnergyW-1:0] g;
        results_checked++;
        if (expected_peaks.size() == 0) begin
            count_mismatch($sformatf("unexpected result %h", got));
            return;
        end
        want = expected_peaks.pop_front();
        for (int i = 0; i < 6; i++) begin
            w = want[95 - 16*i -: 16];
            g = got[95 - 16*i -: 16];
            if (w !== g)
                count_mismatch($sformatf("result %0d %s expected %0d actual %0d",
                                         results_checked, field_names[i], w, g));
        end
    endfunction

    function void flag_leftovers();
        if (expected_peaks.size() != 0) begin
            mismatches += expected_peaks.size();
            $display("%0d expected results never arrived", expected_peaks.size());
        end
    endfunction
endclass

module calo_tower_region_max_veto_unit_tb;

    localparam int FAR_ETA = -2048;
    localparam int FAR_PHI = 2048;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    tower_in_t           s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    peaks_out_t          m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDatW-1:0]  cfg_data = '0;

    veto_peak_tracker  sb;
    bit                quiet = 1'b0;
    bit                idle_on = 1'b1;
    int                settings_used = 1;

    calo_tower_region_max_veto_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Hard stop
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_peaks(m_data);
    end

    // Result side backpressure in bursts
    initial begin
        repeat (12) @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    function automatic tower_in_t make_tower(int first, int last, int eta, int phi,
                                             int em, int had, int tot,
                                             int le, int lp, int se, int sp);
        tower_in_t t;
        t.first_tower        = first[0];
        t.last_tower         = last[0];
        t.tower_eta          = eta[EtaW-1:0];
        t.tower_phi          = phi[PhiW-1:0];
        t.tower_em_energy    = em[EnergyW-1:0];
        t.tower_had_energy   = had[EnergyW-1:0];
        t.tower_total_energy = tot[EnergyW-1:0];
        t.lead_eta           = le[EtaW-1:0];
        t.lead_phi           = lp[PhiW-1:0];
        t.second_eta         = se[EtaW-1:0];
        t.second_phi         = sp[PhiW-1:0];
        return t;
    endfunction

    // One tower beat, with an optional idle burst ahead of it
    task automatic send_tower(input tower_in_t t);
        if (!quiet && idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        sb.note_tower(t);
    endtask

    // Stop sending and let the pipeline empty before touching registers
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_peaks.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(input int phi_half, input int eta_half, input int em_edge,
                                input int had_edge, input int endcap_edge,
                                input int fwd_inner, input int fwd_outer);
        logic [CfgIdxW-1:0] idx[7];
        int                 val[7];
        idx = '{REG_CONE_PHI_HALF, REG_CONE_ETA_HALF, REG_EM_BARREL_EDGE,
                REG_HAD_BARREL_EDGE, REG_ENDCAP_OUTER_EDGE, REG_FORWARD_INNER_EDGE,
                REG_FORWARD_OUTER_EDGE};
        val = '{phi_half, eta_half, em_edge, had_edge, endcap_edge, fwd_inner, fwd_outer};
        for (int i = 0; i < 7; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i][11:0];
            do @(posedge aclk); while (!cfg_ready);
            sb.set_reg(idx[i], val[i][11:0]);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Eta near a region edge, near an electron, or anywhere
    function automatic int pick_eta(int near_eta);
        int edge_val;
        int r;
        int span;
        span = sb.eta_half + 2;
        case ($urandom_range(0, 6))
            0, 1: begin
                case ($urandom_range(0, 4))
                    0: edge_val = sb.em_edge;
                    1: edge_val = sb.had_edge;
                    2: edge_val = sb.endcap_edge;
                    3: edge_val = sb.fwd_inner;
                    default: edge_val = sb.fwd_outer;
                endcase
                r = edge_val + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1)) r = -r;
            end
            2, 3: r = near_eta + int'($urandom_range(0, 2 * span)) - span;
            4: r = int'($urandom_range(0, 4095)) - 2048;
            5: r = int'($urandom_range(0, 800)) - 400;
            default: begin
                case ($urandom_range(0, 2))
                    0: r = -2048;
                    1: r = 2047;
                    default: r = 0;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic int pick_phi(int near_phi);
        int span;
        span = ((sb.phi_half > 2048) ? 2048 : sb.phi_half) + 2;
        case ($urandom_range(0, 5))
            0, 1, 2: return near_phi + int'($urandom_range(0, 2 * span)) - span;
            3: return near_phi + 2048;
            default: return int'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic int pick_energy();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 65535;
            2: return int'($urandom_range(0, 255));
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int pick_electron_eta();
        if ($urandom_range(0, 1)) return int'($urandom_range(0, 4095)) - 2048;
        return int'($urandom_range(0, 800)) - 400;
    endfunction

    function automatic tower_in_t random_tower(int le, int lp, int se, int sp);
        int ne;
        int np;
        if ($urandom_range(0, 1)) begin
            ne = le;
            np = lp;
        end else begin
            ne = se;
            np = sp;
        end
        return make_tower(0, 0, pick_eta(ne), pick_phi(np), pick_energy(), pick_energy(),
                          pick_energy(), le, lp, se, sp);
    endfunction

    // Mostly complete events sharing one electron pair; some stray towers
    task automatic run_random(input int n_items);
        int        sent;
        int        len;
        int        le, lp, se, sp;
        tower_in_t t;
        sent = 0;
        while (sent < n_items) begin
            idle_on = ($urandom_range(0, 9) >= 3);
            le = pick_electron_eta();
            lp = $urandom_range(0, 4095);
            se = pick_electron_eta();
            sp = $urandom_range(0, 4095);
            if ($urandom_range(0, 99) < 85) begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    t = random_tower(le, lp, se, sp);
                    t.first_tower = (k == 0);
                    t.last_tower  = (k == len - 1);
                    send_tower(t);
                    sent++;
                end
            end else begin
                t = random_tower(le, lp, se, sp);
                t.first_tower = 1'($urandom_range(0, 1));
                t.last_tower  = 1'($urandom_range(0, 1));
                send_tower(t);
                sent++;
            end
        end
    endtask

    // Region edges, cone boundaries and event framing under default registers
    task automatic run_directed();
        send_tower(make_tower(1, 0, 0, 0, 65535, 65535, 65535, FAR_ETA, FAR_PHI, FAR_ETA, FAR_PHI));
        send_tower(make_tower(0, 1, 379, 100, 1234, 2345, 3456, FAR_ETA, FAR_PHI, FAR_ETA, FAR_PHI));
        send_tower(make_tower(1, 0, 334, 200, 111, 222, 333, FAR_ETA, FAR_PHI, FAR_ETA, FAR_PHI));
        send_tower(make_tower(0, 0, 768, 300, 444, 555, 666, FAR_ETA, FAR_PHI, FAR_ETA, FAR_PHI));
        send_tower(make_tower(0, 0, 742, 400, 777, 888, 999, FAR_ETA, FAR_PHI, FAR_ETA, FAR_PHI));
        send_tower(make_tower(0, 0, 1331, 500, 4000, 4000, 4000, FAR_ETA, FAR_PHI, FAR_ETA, FAR_PHI));
        send_tower(make_tower(0, 0, -1000, 600, 50, 60, 70, FAR_ETA, FAR_PHI, FAR_ETA, FAR_PHI));
        send_tower(make_tower(0, 0, -2048, 700, 65535, 65535, 65535, FAR_ETA, FAR_PHI,
                              FAR_ETA, FAR_PHI));
        send_tower(make_tower(0, 1, 2047, 4095, 65535, 65535, 65535, FAR_ETA, FAR_PHI,
                              FAR_ETA, FAR_PHI));
        // cone veto on lead electron, then just inside and just outside in phi
        send_tower(make_tower(1, 0, 100, 500, 9000, 9000, 9000, 100, 500, FAR_ETA, FAR_PHI));
        send_tower(make_tower(0, 0, 100, 955, 8000, 8000, 8000, 100, 500, FAR_ETA, FAR_PHI));
        send_tower(make_tower(0, 0, 100, 956, 100, 100, 100, 100, 500, FAR_ETA, FAR_PHI));
        // second electron across the phi wrap, inside and exactly on the eta bound
        send_tower(make_tower(0, 0, -300, 4090, 7000, 7000, 7000, FAR_ETA, FAR_PHI, -263, 10));
        send_tower(make_tower(0, 0, -300, 4090, 200, 200, 200, FAR_ETA, FAR_PHI, -262, 10));
        // forward tower on top of an electron is not an EM region, so no veto
        send_tower(make_tower(0, 1, 1000, 500, 9999, 9999, 9999, 1000, 500, FAR_ETA, FAR_PHI));
        // vetoed last tower still emits
        send_tower(make_tower(1, 0, 10, 10, 300, 300, 300, FAR_ETA, FAR_PHI, FAR_ETA, FAR_PHI));
        send_tower(make_tower(0, 1, 10, 10, 60000, 60000, 60000, 10, 10, FAR_ETA, FAR_PHI));
        // no first_tower after an emission, half-turn phi difference
        send_tower(make_tower(0, 0, -50, 2000, 400, 400, 400, FAR_ETA, FAR_PHI, FAR_ETA, FAR_PHI));
        send_tower(make_tower(0, 1, -50, 2048, 500, 500, 500, -50, 0, FAR_ETA, FAR_PHI));
        // single-tower event with zero energy
        send_tower(make_tower(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // Main sequence
    initial begin
        int guard;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();
        run_random(200);
        drain();

        // maximum register values, cone covers every phi
        program_regs(4095, 2047, 2047, 2047, 2047, 2047, 2047);
        run_random(170);
        drain();

        // all zero: cone never hit, every region empty
        program_regs(0, 0, 0, 0, 0, 0, 0);
        run_random(170);
        drain();

        // inconsistent edges, phi bound at exactly half a turn
        program_regs(2048, 200, 600, 100, 300, 1331, 742);
        run_random(170);
        drain();

        // overlapping regions
        program_regs(2049, 0, 50, 900, 2047, 0, 2047);
        run_random(170);
        drain();

        program_regs($urandom_range(0, 2048), $urandom_range(0, 2047),
                     $urandom_range(0, 2047), $urandom_range(0, 2047),
                     $urandom_range(0, 2047), $urandom_range(0, 2047),
                     $urandom_range(0, 2047));
        run_random(170);
        drain();

        // defaults again with the unused top data bit set; no idling from here on
        quiet = 1'b1;
        program_regs(RST_CONE_PHI_HALF, 'h800 | RST_CONE_ETA_HALF,
                     'h800 | RST_EM_BARREL_EDGE, 'h800 | RST_HAD_BARREL_EDGE,
                     'h800 | RST_ENDCAP_OUTER_EDGE, 'h800 | RST_FORWARD_INNER_EDGE,
                     'h800 | RST_FORWARD_OUTER_EDGE);
        run_random(200);

        s_valid <= 1'b0;
        guard = 0;
        while (sb.expected_peaks.size() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        sb.flag_leftovers();

        $display("Sent %0d towers across %0d register settings; %0d region-max beats checked",
                 sb.towers_seen, settings_used, sb.results_checked);
        $display("Mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
